// File: design/gpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gpr_pkg;

  localparam int PIX_W      = 16;
  localparam int NTAP       = 12;
  localparam int NPAIR      = 6;
  localparam int PAIR_W     = 17;
  localparam int COEF_W     = 9;
  localparam int PROD_W     = 26;
  localparam int SUM_W      = 28;
  localparam int KSHIFT     = 11;
  localparam int STORE_ROWS = 11;
  localparam int SLOT_W     = 4;
  localparam int CFG_W      = 11;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [NTAP-1:0] win_t;

  // Binomial weights, outermost tap pair first; they sum to 2048 over both halves.
  localparam logic [COEF_W-1:0] KCOEF [NPAIR] = '{9'd1, 9'd11, 9'd55, 9'd165, 9'd330, 9'd462};

  // Register indexes of the configuration port.
  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_IN_HEIGHT = 1'b1;

endpackage
`default_nettype wire

// File: design/gpr_tap_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module gpr_tap_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire gpr_pkg::pix_t din,
  output gpr_pkg::pix_t      dout
);
  import gpr_pkg::*;

  // One tap of the window; it takes its neighbor's sample on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= din;
    end
  end

endmodule
`default_nettype wire

// File: design/gpr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write at the same address return the old word.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: design/gpr_kernel.sv
`timescale 1ns / 1ps
`default_nettype none
module gpr_kernel (
  input  wire logic          clk,
  input  wire logic          en_pair,
  input  wire logic          en_prod,
  input  wire logic          en_sum,
  input  wire gpr_pkg::win_t taps,
  output gpr_pkg::pix_t      result
);
  import gpr_pkg::*;

  logic [PAIR_W-1:0] pair [NPAIR];
  logic [PROD_W-1:0] prod [NPAIR];
  logic [SUM_W-1:0]  total;

  // Three stages: symmetric pair sums, constant products, final sum and scale.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NPAIR; k++) begin
      if (en_pair) begin
        pair[k] <= PAIR_W'(taps[k]) + PAIR_W'(taps[NTAP-1-k]);
      end
      if (en_prod) begin
        prod[k] <= PROD_W'(pair[k]) * PROD_W'(KCOEF[k]);
      end
    end
    if (en_sum) begin
      result <= total[KSHIFT +: PIX_W];
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < NPAIR; k++) begin
      total = total + SUM_W'(prod[k]);
    end
  end

endmodule
`default_nettype wire

// File: design/gaussian_pyramid_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: pixel[15:0]; tuser: start_of_frame
// m_axis    out        tdata: value[15:0], out_x[24:16], out_y[33:25]; tlast: last_of_frame
// apb       in/out     reg 0 in_width at 0x0, reg 1 in_height at 0x4
//
// One pixel item is taken per clock while s_tready is high. A result passes
// through the registered stages of horizontal filter, row-store read and
// vertical filter, in that order.
// Each stage holds a valid flag and moves on when the stage after it is free,
// so a waiting result stalls input only once every stage behind it is full.
// Synchronous reset clears counters, taps and valid flags; the row store is
// not cleared and needs no clearing pass.
module gaussian_pyramid_reduce #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // pixel
  input  wire logic        s_tuser,   // start_of_frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // value, out_x, out_y, zero fill
  output logic             m_tlast,   // last_of_frame
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gpr_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int XW   = CW - 1;
  localparam int HALF = MAX_WIDTH / 2;
  localparam int EW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  typedef struct packed {
    logic              hev;   // a horizontal result is formed and stored
    logic              vev;   // a coarse sample is emitted
    logic              last;
    logic [XW-1:0]     x;
    logic [8:0]        ox;
    logic [8:0]        oy;
    logic [SLOT_W-1:0] slot;
  } meta_t;

  // Configuration registers.
  logic [CFG_W-1:0] in_width, in_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= CFG_W'(1024);
      in_height <= CFG_W'(1024);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IN_WIDTH) begin
        in_width <= pwdata[CFG_W-1:0];
      end else begin
        in_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_IN_WIDTH) ? 32'(in_width) : 32'(in_height);

  // Effective size: low bit cleared, at least 16, at most MAX_WIDTH.
  function automatic logic [EW-1:0] eff_size(input logic [CFG_W-1:0] r);
    logic [EW-1:0] s;
    s = EW'({r[CFG_W-1:1], 1'b0});
    if (s < EW'(16)) s = EW'(16);
    if (s > EW'(MAX_WIDTH)) s = EW'(MAX_WIDTH);
    return s;
  endfunction

  logic [EW-1:0] w, h, lw, lh;
  assign w  = eff_size(in_width);
  assign h  = eff_size(in_height);
  assign lw = w >> 1;
  assign lh = h >> 1;

  // Stage handshake: rdy[k] says stage k may load this cycle.
  logic [7:1] v, rdy;
  logic       accept;

  assign rdy[7]   = !v[7] || m_tready;
  assign rdy[6]   = !v[6] || rdy[7];
  assign rdy[5]   = !v[5] || rdy[6];
  assign rdy[4]   = !v[4] || rdy[5];
  assign rdy[3]   = !v[3] || rdy[4];
  assign rdy[2]   = !v[2] || rdy[3];
  assign rdy[1]   = !v[1] || rdy[2];
  assign s_tready = rdy[1];
  assign accept   = s_tvalid && rdy[1];

  // Position counters; slot tracks row_count modulo the store depth.
  logic [CW-1:0]     column_count, row_count;
  logic [SLOT_W-1:0] slot;
  logic [CW-1:0]     c0, r0;
  logic [SLOT_W-1:0] slot0;
  logic [CW:0]       cn, rn;
  logic [XW-1:0]     x0, y0;
  meta_t             meta0;

  always_comb begin
    c0    = s_tuser ? '0 : column_count;
    r0    = s_tuser ? '0 : row_count;
    slot0 = s_tuser ? '0 : slot;
    x0    = c0[CW-1:1] - XW'(3);
    y0    = r0[CW-1:1] - XW'(3);
    cn    = (CW+1)'(c0) + 1'b1;
    rn    = (CW+1)'(r0) + 1'b1;

    meta0.hev  = !c0[0] && (c0 >= CW'(12)) && (EW'(x0) + EW'(4) <= lw);
    meta0.vev  = meta0.hev && !r0[0] && (r0 >= CW'(12)) && (EW'(y0) + EW'(4) <= lh);
    meta0.last = (EW'(x0) + EW'(4) == lw) && (EW'(y0) + EW'(4) == lh);
    meta0.x    = x0;
    meta0.ox   = 9'(x0);
    meta0.oy   = 9'(y0);
    meta0.slot = slot0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      slot         <= '0;
    end else if (accept) begin
      if (EW'(cn) >= w) begin
        column_count <= '0;
        if (EW'(rn) >= h) begin
          row_count <= '0;
          slot      <= '0;
        end else begin
          row_count <= rn[CW-1:0];
          slot      <= (slot0 == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot0 + 1'b1;
        end
      end else begin
        column_count <= cn[CW-1:0];
        row_count    <= r0;
        slot         <= slot0;
      end
    end
  end

  // Chain of tap cells: the last eleven pixels of the row, oldest in cell 0.
  pix_t tap_q [STORE_ROWS];
  win_t hwin;

  for (genvar i = 0; i < STORE_ROWS; i++) begin : g_tap
    pix_t din;
    if (i == STORE_ROWS - 1) begin : g_head
      assign din = s_tdata;
    end else begin : g_body
      assign din = tap_q[i+1];
    end
    gpr_tap_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (accept),
      .din  (din),
      .dout (tap_q[i])
    );
    assign hwin[i] = tap_q[i];
  end
  assign hwin[NTAP-1] = s_tdata;

  // Horizontal filter, stages 1 to 3.
  pix_t hv3;

  gpr_kernel u_hfilt (
    .clk     (clk),
    .en_pair (rdy[1]),
    .en_prod (rdy[2]),
    .en_sum  (rdy[3]),
    .taps    (hwin),
    .result  (hv3)
  );

  // Valid flags and side data of each stage.
  meta_t meta [1:7];
  pix_t  hv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
      if (rdy[7]) v[7] <= v[6] && meta[6].vev;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) meta[1] <= meta0;
    for (int k = 2; k <= 7; k++) begin
      if (rdy[k]) meta[k] <= meta[k-1];
    end
    if (rdy[4]) hv4 <= hv3;
  end

  // Row store: one memory per stored row, all read at column x while the
  // new horizontal result is written into the oldest row's slot.
  pix_t rd [STORE_ROWS];

  for (genvar i = 0; i < STORE_ROWS; i++) begin : g_row
    gpr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (HALF)
    ) u_ram (
      .clk   (clk),
      .en    (rdy[4]),
      .we    (rdy[4] && v[3] && meta[3].hev && (meta[3].slot == SLOT_W'(i))),
      .addr  (meta[3].x),
      .wdata (hv3),
      .rdata (rd[i])
    );
  end

  // Rotate the rows so the oldest comes first, then add the current row.
  win_t vwin;

  always_comb begin
    logic [SLOT_W:0] idx;
    for (int k = 0; k < STORE_ROWS; k++) begin
      idx = (SLOT_W+1)'(meta[4].slot) + (SLOT_W+1)'(k);
      if (idx >= (SLOT_W+1)'(STORE_ROWS)) idx = idx - (SLOT_W+1)'(STORE_ROWS);
      vwin[k] = rd[idx[SLOT_W-1:0]];
    end
    vwin[NTAP-1] = hv4;
  end

  // Vertical filter, stages 5 to 7; its last register is the output.
  pix_t value;

  gpr_kernel u_vfilt (
    .clk     (clk),
    .en_pair (rdy[5]),
    .en_prod (rdy[6]),
    .en_sum  (rdy[7]),
    .taps    (vwin),
    .result  (value)
  );

  assign m_tvalid = v[7];
  assign m_tdata  = {6'd0, meta[7].oy, meta[7].ox, value};
  assign m_tlast  = meta[7].last;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import gpr_pkg::*;

  // Expected coarse sample as the block should emit it.
  typedef struct packed {
    logic [15:0] value;
    logic [8:0]  x;
    logic [8:0]  y;
    logic        last;
  } coarse_t;

  // Tracks the pyramid step in software and checks each coarse sample.
  class coarse_board;
    logic [10:0] width_reg, height_reg;
    logic [15:0] taps [11];
    logic [15:0] rows [11][512];
    int unsigned col, row;
    coarse_t pending [$];
    int errors;

    function new();
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      foreach (taps[k]) taps[k] = '0;
      foreach (rows[a, b]) rows[a][b] = '0;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function int unsigned size_of(logic [10:0] r);
      int unsigned s;
      s = 32'(r & 11'h7fe);
      if (s < 16) s = 16;
      if (s > 1024) s = 1024;
      return s;
    endfunction

    // Binomial sum over eleven older taps and the newest one, shifted by 11.
    function logic [15:0] binomial(logic [15:0] t [11], logic [15:0] c);
      logic [31:0] s;
      s = (t[0] + c) + (t[1] + t[10]) * 11 + (t[2] + t[9]) * 55
        + (t[3] + t[8]) * 165 + (t[4] + t[7]) * 330 + (t[5] + t[6]) * 462;
      return s[26:11];
    endfunction

    function void note_pixel(logic [15:0] pix, logic sof);
      int unsigned w, h, lw, lh, x, y, k;
      logic [15:0] hv;
      logic [15:0] colv [11];
      coarse_t e;
      w = size_of(width_reg);
      h = size_of(height_reg);
      lw = w / 2;
      lh = h / 2;
      if (sof) begin
        col = 0;
        row = 0;
      end
      if (col[0] == 1'b0 && col >= 12) begin
        x = (col - 6) / 2;
        if (x >= 3 && x + 4 <= lw && x < 512) begin
          hv = binomial(taps, pix);
          if (row[0] == 1'b0 && row >= 12) begin
            y = (row - 6) / 2;
            if (y >= 3 && y + 4 <= lh) begin
              for (k = 0; k < 11; k++) colv[k] = rows[(row + k) % 11][x];
              e.value = binomial(colv, hv);
              e.x = 9'(x);
              e.y = 9'(y);
              e.last = (x + 4 == lw && y + 4 == lh);
              pending = {pending, e};
            end
          end
          rows[row % 11][x] = hv;
        end
      end
      for (k = 0; k < 10; k++) taps[k] = taps[k + 1];
      taps[10] = pix;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_sample(logic [15:0] v, logic [8:0] x, logic [8:0] y, logic l);
      coarse_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample v=%0d x=%0d y=%0d", v, x, y);
        return;
      end
      e = pending.pop_front();
      if (e.value !== v || e.x !== x || e.y !== y || e.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp v=%0d x=%0d y=%0d l=%0b got v=%0d x=%0d y=%0d l=%0b",
                   e.value, e.x, e.y, e.last, v, x, y, l);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [15:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [39:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  gaussian_pyramid_reduce uut (.*);

  coarse_board board;
  int send_idle, recv_stall;
  int quiet_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Results are checked as they are accepted; the receiver stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        board.check_sample(m_tdata[15:0], m_tdata[24:16], m_tdata[33:25], m_tlast);
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side is a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Register writes: setup then access, with pready always high.
  task automatic write_reg(logic reg_index, logic [10:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= {21'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_index == REG_IN_WIDTH) board.width_reg = v;
    else board.height_reg = v;
  endtask

  // Offers one pixel, idling first at the current rate; returns once accepted.
  task automatic send_pixel(logic [15:0] pix, logic sof);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_pixel(pix, sof);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One whole frame of random content; mostly smooth data, sometimes noisy extremes.
  task automatic send_frame(int w, int h);
    int i, j;
    logic [15:0] p;
    for (i = 0; i < h; i++)
      for (j = 0; j < w; j++) begin
        case ($urandom_range(3))
          0: p = 16'($urandom);
          1: p = ($urandom_range(1)) ? 16'hffff : 16'h0000;
          default: p = 16'(16'h8000 + $urandom_range(4095));
        endcase
        send_pixel(p, i == 0 && j == 0);
      end
  endtask

  initial begin
    int phase;
    board = new();
    rst = 1'b1;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one row of the smallest frame, then a width below range and an odd height so the clamp applies.
    write_reg(REG_IN_WIDTH, 11'd16);
    write_reg(REG_IN_HEIGHT, 11'd16);
    send_frame(16, 1);
    settle();
    write_reg(REG_IN_WIDTH, 11'd3);
    write_reg(REG_IN_HEIGHT, 11'd17);
    send_frame(16, 16);
    settle();

    // Random frames over four phases of input idling and output stalling.
    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 22 : 83) : 0;
      recv_stall = (phase == 2) ? 83 : ((phase == 3) ? 22 : 0);
      write_reg(REG_IN_WIDTH, 11'(16 + 2 * $urandom_range(2)));
      write_reg(REG_IN_HEIGHT, 11'(16 + 2 * $urandom_range(2)));
      send_frame(board.size_of(board.width_reg), board.size_of(board.height_reg));
      settle();
    end

    // A short start of a wide frame reaches the largest width and the top register bit.
    send_idle = 0;
    recv_stall = 10;
    write_reg(REG_IN_WIDTH, 11'h7ff);
    write_reg(REG_IN_HEIGHT, 11'd16);
    send_frame(64, 1);
    settle();

    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
